// ----- design/v_plotter_dual_stepper_mover_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the plotter mover unit.
// Same-cycle and next-cycle implication checks, both disabled during reset.
// ----------------------------------------------------------------------------
`ifndef V_PLOTTER_DUAL_STEPPER_MOVER_UNIT_ASSERT_SVH
`define V_PLOTTER_DUAL_STEPPER_MOVER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VPDSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VPDSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/vpdsm_pkg.sv -----
// ----------------------------------------------------------------------------
// vpdsm_pkg
// Shared types, widths and codes of the two-belt plotter mover.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vpdsm_pkg;

   localparam int LENGTH_BITS   = 24;
   localparam int WAIT_BITS     = LENGTH_BITS + 16;
   localparam int DIVD_BITS     = WAIT_BITS + 1;
   localparam int DIV_CNT_BITS  = $clog2(DIVD_BITS);
   localparam int COORD_BITS    = 18;
   localparam int MAG_BITS      = 17;
   localparam int SQR_BITS      = 34;
   localparam int RAD_BITS      = 35;
   localparam int ROOT_BITS     = 18;
   localparam int SCALE_BITS    = 34;
   localparam int ROOT_ITERS    = 18;
   localparam int ROOT_CNT_BITS = 5;

   // Action codes
   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_MOVE = 2'd1;
   localparam logic [1:0] ACT_SETP = 2'd2;
   localparam logic [1:0] ACT_NONE = 2'd3;

   // Register indexes
   localparam logic [2:0] CSR_SPAN         = 3'd0;
   localparam logic [2:0] CSR_SHEET_LEFT   = 3'd1;
   localparam logic [2:0] CSR_SHEET_BOTTOM = 3'd2;
   localparam logic [2:0] CSR_STEPS_UNIT   = 3'd3;
   localparam logic [2:0] CSR_STEP_DELAY   = 3'd4;
   localparam logic [2:0] CSR_LEFT_PULL    = 3'd5;
   localparam logic [2:0] CSR_RIGHT_PULL   = 3'd6;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] target_x;
      logic signed [15:0] target_y;
   } req_type;

   typedef struct packed {
      logic left_step_pin;
      logic left_dir_pin;
      logic right_step_pin;
      logic right_dir_pin;
      logic left_pulse;
      logic right_pulse;
      logic busy_res;
      logic rejected;
   } rsp_type;

   typedef struct packed {
      logic [15:0] span;
      logic [15:0] sheet_left;
      logic [15:0] sheet_bottom;
      logic [15:0] steps_per_unit;
      logic [15:0] step_delay_ticks;
      logic        left_pull_level;
      logic        right_pull_level;
   } cfg_type;

   // Classified command: action plus the belt geometry offsets
   typedef struct packed {
      logic [1:0]                   kind;
      logic signed [COORD_BITS-1:0] h_left;
      logic signed [COORD_BITS-1:0] h_right;
      logic signed [COORD_BITS-1:0] v_off;
   } item_type;

endpackage

// ----- design/vpdsm_front.sv -----
// ----------------------------------------------------------------------------
// vpdsm_front
// Accepts command words, works out belt offsets and queues them (two deep).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "v_plotter_dual_stepper_mover_unit_assert.svh"

module vpdsm_front (
   input  logic                clock,
   input  logic                reset,
   input  vpdsm_pkg::cfg_type  cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  vpdsm_pkg::req_type  req_data,
   output logic                q_valid,
   output vpdsm_pkg::item_type q_item,
   input  logic                q_pop
);
   import vpdsm_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   item_new;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   // Classify and precompute h and v for both belts
   always_comb begin
      item_new.kind    = req_data.action;
      item_new.h_left  = COORD_BITS'($signed({2'b00, cfg.sheet_left}))
                       + COORD_BITS'(req_data.target_x);
      item_new.h_right = COORD_BITS'($signed({2'b00, cfg.span}))
                       - COORD_BITS'($signed({2'b00, cfg.sheet_left}))
                       - COORD_BITS'(req_data.target_x);
      item_new.v_off   = COORD_BITS'($signed({2'b00, cfg.sheet_bottom}))
                       - COORD_BITS'(req_data.target_y);
   end

   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_new;
      end
   end

   `VPDSM_ASSERT_NOW(a_pop_not_empty, clock, reset, q_pop, count_ff != 2'd0,
      "pop from empty queue")
   `VPDSM_ASSERT_NEXT(a_fill_grows, clock, reset, push && !q_pop,
      count_ff == $past(count_ff) + 2'd1, "queue count did not grow on push")
   `VPDSM_ASSERT_NEXT(a_drain_shrinks, clock, reset, q_pop && !push,
      count_ff == $past(count_ff) - 2'd1, "queue count did not shrink on pop")

endmodule

// ----- design/vpdsm_back.sv -----
// ----------------------------------------------------------------------------
// vpdsm_back
// Executes queued commands: ticks, belt length solve, step plan, result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "v_plotter_dual_stepper_mover_unit_assert.svh"

module vpdsm_back (
   input  logic                clock,
   input  logic                reset,
   input  vpdsm_pkg::cfg_type  cfg,
   input  logic                q_valid,
   input  vpdsm_pkg::item_type q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output vpdsm_pkg::rsp_type  rsp_data
);
   import vpdsm_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SQR   = 4'd1;
   localparam logic [3:0] ST_SUM   = 4'd2;
   localparam logic [3:0] ST_ROOT  = 4'd3;
   localparam logic [3:0] ST_SCALE = 4'd4;
   localparam logic [3:0] ST_APPLY = 4'd5;
   localparam logic [3:0] ST_MUL   = 4'd6;
   localparam logic [3:0] ST_DIVI  = 4'd7;
   localparam logic [3:0] ST_DIV   = 4'd8;
   localparam logic [3:0] ST_FIN   = 4'd9;

   logic [3:0]             state_ff, state_in;
   item_type               cmd_ff, cmd_in;
   logic                   axis_ff, axis_in;
   logic [SQR_BITS-1:0]    hh_ff, hh_in, vv_ff, vv_in;
   logic [RAD_BITS-1:0]    rad_ff, rad_in;
   logic [RAD_BITS:0]      root_ff, root_in, bit_ff, bit_in;
   logic [ROOT_CNT_BITS-1:0] rcnt_ff, rcnt_in;
   logic [LENGTH_BITS-1:0] lt_ff, lt_in, rt_ff, rt_in;
   logic                   major_left_ff, major_left_in;
   logic [LENGTH_BITS-1:0] nmin_ff, nmin_in;
   logic [WAIT_BITS-1:0]   mprod_ff, mprod_in;
   logic [DIVD_BITS-1:0]   quo_ff, quo_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [DIV_CNT_BITS-1:0] dcnt_ff, dcnt_in;

   logic [LENGTH_BITS-1:0] left_len_ff, left_len_in, right_len_ff, right_len_in;
   logic [LENGTH_BITS-1:0] left_todo_ff, left_todo_in, right_todo_ff, right_todo_in;
   logic [WAIT_BITS-1:0]   left_wait_ff, left_wait_in, right_wait_ff, right_wait_in;
   logic [WAIT_BITS-1:0]   left_el_ff, left_el_in, right_el_ff, right_el_in;
   logic                   left_pull_ff, left_pull_in, right_pull_ff, right_pull_in;

   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_data_ff, out_data_in;

   logic                   out_free, busy, out_load, lp, rp, rej;
   logic [WAIT_BITS-1:0]   left_e1, right_e1;
   logic signed [COORD_BITS-1:0] h_sel;
   logic [MAG_BITS-1:0]    ah, av;
   logic [RAD_BITS:0]      trial;
   logic [SCALE_BITS-1:0]  scaled;
   logic signed [LENGTH_BITS:0] dl, dr;
   logic [LENGTH_BITS-1:0] nmax;
   logic [LENGTH_BITS:0]   rem_sh;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign busy      = (left_todo_ff != '0) || (right_todo_ff != '0);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign q_pop     = (state_ff == ST_IDLE) && q_valid && out_free;

   assign left_e1  = left_el_ff + WAIT_BITS'(1);
   assign right_e1 = right_el_ff + WAIT_BITS'(1);
   assign h_sel    = axis_ff ? cmd_ff.h_right : cmd_ff.h_left;
   assign ah       = MAG_BITS'(h_sel[COORD_BITS-1] ? -h_sel : h_sel);
   assign av       = MAG_BITS'(cmd_ff.v_off[COORD_BITS-1] ? -cmd_ff.v_off : cmd_ff.v_off);
   assign trial    = root_ff + bit_ff;
   assign scaled   = root_ff[ROOT_BITS-1:0] * cfg.steps_per_unit;
   assign dl       = $signed({1'b0, lt_ff}) - $signed({1'b0, left_len_ff});
   assign dr       = $signed({1'b0, rt_ff}) - $signed({1'b0, right_len_ff});
   assign nmax     = (left_todo_ff > right_todo_ff) ? left_todo_ff : right_todo_ff;
   assign rem_sh   = {rem_ff, quo_ff[DIVD_BITS-1]};

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      axis_in        = axis_ff;
      hh_in          = hh_ff;
      vv_in          = vv_ff;
      rad_in         = rad_ff;
      root_in        = root_ff;
      bit_in         = bit_ff;
      rcnt_in        = rcnt_ff;
      lt_in          = lt_ff;
      rt_in          = rt_ff;
      major_left_in  = major_left_ff;
      nmin_in        = nmin_ff;
      mprod_in       = mprod_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      dcnt_in        = dcnt_ff;
      left_len_in    = left_len_ff;
      right_len_in   = right_len_ff;
      left_todo_in   = left_todo_ff;
      right_todo_in  = right_todo_ff;
      left_wait_in   = left_wait_ff;
      right_wait_in  = right_wait_ff;
      left_el_in     = left_el_ff;
      right_el_in    = right_el_ff;
      left_pull_in   = left_pull_ff;
      right_pull_in  = right_pull_ff;
      out_load       = 1'b0;
      lp             = 1'b0;
      rp             = 1'b0;
      rej            = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               case (q_item.kind)
                  ACT_TICK: begin
                     out_load = 1'b1;
                     if (left_todo_ff != '0) begin
                        if (left_e1 >= left_wait_ff) begin
                           lp           = 1'b1;
                           left_el_in   = '0;
                           left_todo_in = left_todo_ff - LENGTH_BITS'(1);
                           left_len_in  = left_pull_ff ? left_len_ff - LENGTH_BITS'(1)
                                                       : left_len_ff + LENGTH_BITS'(1);
                        end else begin
                           left_el_in = left_e1;
                        end
                     end
                     if (right_todo_ff != '0) begin
                        if (right_e1 >= right_wait_ff) begin
                           rp            = 1'b1;
                           right_el_in   = '0;
                           right_todo_in = right_todo_ff - LENGTH_BITS'(1);
                           right_len_in  = right_pull_ff ? right_len_ff - LENGTH_BITS'(1)
                                                         : right_len_ff + LENGTH_BITS'(1);
                        end else begin
                           right_el_in = right_e1;
                        end
                     end
                  end
                  ACT_MOVE, ACT_SETP: begin
                     if (busy) begin
                        out_load = 1'b1;
                        rej      = 1'b1;
                     end else begin
                        cmd_in   = q_item;
                        axis_in  = 1'b0;
                        state_in = ST_SQR;
                     end
                  end
                  default: begin
                     out_load = 1'b1;
                  end
               endcase
            end
         end
         ST_SQR: begin
            hh_in    = ah * ah;
            vv_in    = av * av;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            rad_in   = {1'b0, hh_ff} + {1'b0, vv_ff};
            root_in  = '0;
            bit_in   = (RAD_BITS+1)'(1) << (2 * (ROOT_ITERS - 1));
            rcnt_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            // One result bit per cycle
            if ({1'b0, rad_ff} >= trial) begin
               rad_in  = RAD_BITS'({1'b0, rad_ff} - trial);
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            rcnt_in = rcnt_ff + ROOT_CNT_BITS'(1);
            if (rcnt_ff == ROOT_CNT_BITS'(ROOT_ITERS - 1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (axis_ff) begin
               rt_in    = LENGTH_BITS'(scaled >> 16);
               state_in = ST_APPLY;
            end else begin
               lt_in    = LENGTH_BITS'(scaled >> 16);
               axis_in  = 1'b1;
               state_in = ST_SQR;
            end
         end
         ST_APPLY: begin
            if (cmd_ff.kind == ACT_SETP) begin
               left_len_in  = lt_ff;
               right_len_in = rt_ff;
               state_in     = ST_FIN;
            end else begin
               left_pull_in  = dl[LENGTH_BITS];
               right_pull_in = dr[LENGTH_BITS];
               left_todo_in  = LENGTH_BITS'(dl[LENGTH_BITS] ? -dl : dl);
               right_todo_in = LENGTH_BITS'(dr[LENGTH_BITS] ? -dr : dr);
               left_el_in    = '0;
               right_el_in   = '0;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            major_left_in = left_todo_ff > right_todo_ff;
            nmin_in       = (left_todo_ff > right_todo_ff) ? right_todo_ff : left_todo_ff;
            mprod_in      = cfg.step_delay_ticks * nmax;
            left_wait_in  = WAIT_BITS'(cfg.step_delay_ticks);
            right_wait_in = WAIT_BITS'(cfg.step_delay_ticks);
            // Minor axis idle: both waits are the plain delay
            if (((left_todo_ff > right_todo_ff) ? right_todo_ff : left_todo_ff) == '0) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_DIVI;
            end
         end
         ST_DIVI: begin
            quo_in   = {1'b0, mprod_ff} + DIVD_BITS'(nmin_ff) - DIVD_BITS'(1);
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Restoring divide, one quotient bit per cycle
            if (rem_sh >= {1'b0, nmin_ff}) begin
               rem_in = LENGTH_BITS'(rem_sh - {1'b0, nmin_ff});
               quo_in = {quo_ff[DIVD_BITS-2:0], 1'b1};
            end else begin
               rem_in = LENGTH_BITS'(rem_sh);
               quo_in = {quo_ff[DIVD_BITS-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + DIV_CNT_BITS'(1);
            if (dcnt_ff == DIV_CNT_BITS'(DIVD_BITS - 1)) begin
               if (major_left_ff) begin
                  right_wait_in = quo_in[WAIT_BITS-1:0];
               end else begin
                  left_wait_in = quo_in[WAIT_BITS-1:0];
               end
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_data_in.left_step_pin  = left_len_in[0];
      out_data_in.left_dir_pin   = left_pull_in ? cfg.left_pull_level : !cfg.left_pull_level;
      out_data_in.right_step_pin = right_len_in[0];
      out_data_in.right_dir_pin  = right_pull_in ? cfg.right_pull_level
                                                 : !cfg.right_pull_level;
      out_data_in.left_pulse     = lp;
      out_data_in.right_pulse    = rp;
      out_data_in.busy_res       = (left_todo_in != '0) || (right_todo_in != '0);
      out_data_in.rejected       = rej;

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         out_valid_ff  <= 1'b0;
         left_len_ff   <= '0;
         right_len_ff  <= '0;
         left_todo_ff  <= '0;
         right_todo_ff <= '0;
         left_wait_ff  <= '0;
         right_wait_ff <= '0;
         left_el_ff    <= '0;
         right_el_ff   <= '0;
         left_pull_ff  <= 1'b0;
         right_pull_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         left_len_ff   <= left_len_in;
         right_len_ff  <= right_len_in;
         left_todo_ff  <= left_todo_in;
         right_todo_ff <= right_todo_in;
         left_wait_ff  <= left_wait_in;
         right_wait_ff <= right_wait_in;
         left_el_ff    <= left_el_in;
         right_el_ff   <= right_el_in;
         left_pull_ff  <= left_pull_in;
         right_pull_ff <= right_pull_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      axis_ff       <= axis_in;
      hh_ff         <= hh_in;
      vv_ff         <= vv_in;
      rad_ff        <= rad_in;
      root_ff       <= root_in;
      bit_ff        <= bit_in;
      rcnt_ff       <= rcnt_in;
      lt_ff         <= lt_in;
      rt_ff         <= rt_in;
      major_left_ff <= major_left_in;
      nmin_ff       <= nmin_in;
      mprod_ff      <= mprod_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      dcnt_ff       <= dcnt_in;
      if (out_load) begin
         out_data_ff <= out_data_in;
      end
   end

   `VPDSM_ASSERT_NOW(a_no_pop_while_working, clock, reset, state_ff != ST_IDLE,
      !q_pop, "command popped while a solve is in progress")
   `VPDSM_ASSERT_NEXT(a_busy_rejects, clock, reset,
      q_pop && busy && (q_item.kind == ACT_MOVE || q_item.kind == ACT_SETP),
      out_valid_ff && out_data_ff.rejected, "busy command was not rejected")
   `VPDSM_ASSERT_NEXT(a_fin_returns, clock, reset, state_ff == ST_FIN && out_free,
      state_ff == ST_IDLE && out_valid_ff, "finished command gave no result")

endmodule

// ----- design/v_plotter_dual_stepper_mover_unit.sv -----
// ----------------------------------------------------------------------------
// v_plotter_dual_stepper_mover_unit
// Two-belt plotter mover: command queue, kinematics solver and step timers.
// ----------------------------------------------------------------------------
// A tick word produces its result in the cycle after it leaves the two-deep
// command queue, so ticks sustain one word per cycle when the result side
// does not stall. A move word runs, per belt, a squaring step, an add, a
// bit-per-cycle square root and a scaling multiply, then the step plan with
// a 41-bit by 24-bit restoring divider for the minor axis delay. A
// set-position word runs the two root solves only. Move and set words
// arriving while steps remain are answered at once with rejected set. The
// queue accepts words while the back end solves, until both slots are full.
// Results wait in the output register. Users write configuration registers
// via the csr port only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module v_plotter_dual_stepper_mover_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  vpdsm_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output vpdsm_pkg::rsp_type rsp_data
);
   import vpdsm_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     q_valid, q_pop;
   item_type q_item;

   // Decode register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SPAN:         cfg_in.span             = csr_wdata;
            CSR_SHEET_LEFT:   cfg_in.sheet_left       = csr_wdata;
            CSR_SHEET_BOTTOM: cfg_in.sheet_bottom     = csr_wdata;
            CSR_STEPS_UNIT:   cfg_in.steps_per_unit   = csr_wdata;
            CSR_STEP_DELAY:   cfg_in.step_delay_ticks = csr_wdata;
            CSR_LEFT_PULL:    cfg_in.left_pull_level  = csr_wdata[0];
            CSR_RIGHT_PULL:   cfg_in.right_pull_level = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold configuration; reset to the default geometry
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.span             <= 16'd16000;
         cfg_ff.sheet_left       <= 16'd3200;
         cfg_ff.sheet_bottom     <= 16'd12800;
         cfg_ff.steps_per_unit   <= 16'd4096;
         cfg_ff.step_delay_ticks <= 16'd1000;
         cfg_ff.left_pull_level  <= 1'b1;
         cfg_ff.right_pull_level <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept, precompute offsets, queue
   vpdsm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   // Back: execute commands and drive the result register
   vpdsm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
